### rtl/core/serial_bank_switch_mapper_top_macros.svh
// Assertion macros shared by the mapper modules.
// Every macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef SERIAL_BANK_SWITCH_MAPPER_TOP_MACROS_SVH
`define SERIAL_BANK_SWITCH_MAPPER_TOP_MACROS_SVH

// The condition holds at every clock edge.
`define SBSM_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the premise holds, the consequence holds at the next clock edge.
`define SBSM_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/core/sbsm_pkg.sv
`timescale 1ns / 1ps

package sbsm_pkg;

	localparam logic [1:0] OP_CPU_READ  = 2'd0;
	localparam logic [1:0] OP_CPU_WRITE = 2'd1;
	localparam logic [1:0] OP_PPU_READ  = 2'd2;
	localparam logic [1:0] OP_PPU_WRITE = 2'd3;

	localparam logic [2:0] TGT_NONE    = 3'd0;
	localparam logic [2:0] TGT_PRG_ROM = 3'd1;
	localparam logic [2:0] TGT_PRG_RAM = 3'd2;
	localparam logic [2:0] TGT_CHR     = 3'd3;
	localparam logic [2:0] TGT_NAME    = 3'd4;
	localparam logic [2:0] TGT_PALETTE = 3'd5;

	localparam logic [1:0] SEL_CONTROL  = 2'd0;
	localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
	localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
	localparam logic [1:0] SEL_PRG      = 2'd3;

	localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
	localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

	localparam logic [1:0] MIRROR_ONE_LOW    = 2'd0;
	localparam logic [1:0] MIRROR_ONE_HIGH   = 2'd1;
	localparam logic [1:0] MIRROR_VERTICAL   = 2'd2;
	localparam logic [1:0] MIRROR_HORIZONTAL = 2'd3;

	localparam logic CFG_PRG_COUNT = 1'b0;
	localparam logic CFG_CHR_COUNT = 1'b1;

	localparam logic [4:0] MAX_PRG_BANKS   = 5'd16;
	localparam logic [4:0] MAX_CHR_BANKS   = 5'd16;
	localparam logic [4:0] PRG_COUNT_RESET = 5'd2;
	localparam logic [4:0] CHR_COUNT_RESET = 5'd1;

	localparam logic [2:0] SHIFT_LAST = 3'd4;

	localparam int IN_BITS  = 32;
	localparam int OUT_BITS = 24;

	typedef struct packed {
		logic       chr_mode_4k;
		logic [1:0] prg_mode;
		logic [1:0] mirror_mode;
		logic [4:0] chr_select_low;
		logic [4:0] chr_select_high;
		logic [3:0] prg_select;
		logic [3:0] prg_mask;
		logic       ram_enable;
	} bank_state_t;

endpackage

### rtl/core/sbsm_regs.sv
`timescale 1ns / 1ps
`include "serial_bank_switch_mapper_top_macros.svh"

module sbsm_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [4:0]           cfg_data,
	input  logic                 wr_en,
	input  logic [1:0]           wr_sel,
	input  logic [7:0]           wr_data,
	output sbsm_pkg::bank_state_t state
);

	logic [4:0] prg_count_q;
	logic [4:0] chr_count_q;
	logic [4:0] shift_value_q;
	logic [2:0] shift_count_q;
	logic       chr_mode_4k_q;
	logic [1:0] prg_mode_q;
	logic [1:0] mirror_mode_q;
	logic [4:0] chr_select_low_q;
	logic [4:0] chr_select_high_q;
	logic [3:0] prg_select_q;
	logic       ram_enable_q;

	logic [4:0] prg_n;
	logic [4:0] chr_n;
	logic [3:0] prg_mask;
	logic [4:0] chr_mask;
	logic [2:0] count_used;
	logic [4:0] shift_next;

	always_comb begin
		if (prg_count_q == 5'd0) begin
			prg_n = 5'd1;
		end else if (prg_count_q > sbsm_pkg::MAX_PRG_BANKS) begin
			prg_n = sbsm_pkg::MAX_PRG_BANKS;
		end else begin
			prg_n = prg_count_q;
		end
		if (chr_count_q == 5'd0) begin
			chr_n = 5'd1;
		end else if (chr_count_q > sbsm_pkg::MAX_CHR_BANKS) begin
			chr_n = sbsm_pkg::MAX_CHR_BANKS;
		end else begin
			chr_n = chr_count_q;
		end
	end

	assign prg_mask   = 4'(prg_n - 5'd1);
	assign chr_mask   = 5'({chr_n, 1'b0} - 6'd1);
	assign count_used = (shift_count_q > sbsm_pkg::SHIFT_LAST) ? sbsm_pkg::SHIFT_LAST
		: shift_count_q;
	assign shift_next = shift_value_q | (5'(wr_data[0]) << count_used);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q <= sbsm_pkg::PRG_COUNT_RESET;
			chr_count_q <= sbsm_pkg::CHR_COUNT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == sbsm_pkg::CFG_PRG_COUNT) begin
				prg_count_q <= cfg_data;
			end else begin
				chr_count_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_value_q     <= '0;
			shift_count_q     <= '0;
			chr_mode_4k_q     <= 1'b0;
			prg_mode_q        <= sbsm_pkg::PRG_MODE_FIX_HIGH;
			mirror_mode_q     <= '0;
			chr_select_low_q  <= '0;
			chr_select_high_q <= '0;
			prg_select_q      <= '0;
			ram_enable_q      <= 1'b0;
		end else if (wr_en) begin
			if (wr_data[7]) begin
				shift_value_q <= '0;
				shift_count_q <= '0;
				prg_mode_q    <= sbsm_pkg::PRG_MODE_FIX_HIGH;
			end else if (count_used == sbsm_pkg::SHIFT_LAST) begin
				shift_value_q <= '0;
				shift_count_q <= '0;
				case (wr_sel)
					sbsm_pkg::SEL_CONTROL: begin
						chr_mode_4k_q <= shift_next[4];
						prg_mode_q    <= shift_next[3:2];
						mirror_mode_q <= shift_next[1:0];
					end
					sbsm_pkg::SEL_CHR_LOW: begin
						chr_select_low_q <= shift_next & chr_mask;
					end
					sbsm_pkg::SEL_CHR_HIGH: begin
						chr_select_high_q <= shift_next & chr_mask;
					end
					default: begin
						ram_enable_q <= shift_next[4];
						prg_select_q <= shift_next[3:0] & prg_mask;
					end
				endcase
			end else begin
				shift_value_q <= shift_next;
				shift_count_q <= count_used + 3'd1;
			end
		end
	end

	always_comb begin
		state.chr_mode_4k     = chr_mode_4k_q;
		state.prg_mode        = prg_mode_q;
		state.mirror_mode     = mirror_mode_q;
		state.chr_select_low  = chr_select_low_q;
		state.chr_select_high = chr_select_high_q;
		state.prg_select      = prg_select_q;
		state.prg_mask        = prg_mask;
		state.ram_enable      = ram_enable_q;
	end

	`SBSM_ASSERT_ALWAYS(a_count_range, shift_count_q <= sbsm_pkg::SHIFT_LAST,
		"serial bit count has passed the fifth bit")
	`SBSM_ASSERT_NEXT(a_reset_write, wr_en && wr_data[7],
		shift_count_q == 3'd0 && prg_mode_q == sbsm_pkg::PRG_MODE_FIX_HIGH,
		"reset write did not clear the loader and force the fixed high bank mode")
	`SBSM_ASSERT_NEXT(a_fifth_commit,
		wr_en && !wr_data[7] && shift_count_q == sbsm_pkg::SHIFT_LAST,
		shift_count_q == 3'd0 && shift_value_q == 5'd0,
		"fifth serial bit did not restart the loader")

endmodule

### rtl/core/sbsm_xlate.sv
`timescale 1ns / 1ps

module sbsm_xlate (
	input  logic [1:0]            op,
	input  logic [15:0]           address,
	input  sbsm_pkg::bank_state_t state,
	output logic [2:0]            target,
	output logic [17:0]           phys_address
);

	logic [3:0]  prg_lo;
	logic [3:0]  prg_hi;
	logic [3:0]  prg_bank;
	logic [4:0]  chr_unit;
	logic [10:0] name_off;
	logic [4:0]  pal;
	logic [13:0] ppu_addr;

	assign ppu_addr = address[13:0];

	always_comb begin
		case (state.prg_mode)
			sbsm_pkg::PRG_MODE_FIX_HIGH: begin
				prg_lo = state.prg_select;
				prg_hi = state.prg_mask;
			end
			sbsm_pkg::PRG_MODE_FIX_LOW: begin
				prg_lo = 4'd0;
				prg_hi = state.prg_select;
			end
			default: begin
				prg_lo = state.prg_select & 4'hE & state.prg_mask;
				prg_hi = (prg_lo | 4'd1) & state.prg_mask;
			end
		endcase
		prg_bank = address[14] ? prg_hi : prg_lo;

		if (state.chr_mode_4k) begin
			chr_unit = ppu_addr[12] ? state.chr_select_high : state.chr_select_low;
		end else begin
			chr_unit = {state.chr_select_low[4:1], ppu_addr[12]};
		end

		case (state.mirror_mode)
			sbsm_pkg::MIRROR_ONE_LOW:  name_off = {1'b0, ppu_addr[9:0]};
			sbsm_pkg::MIRROR_ONE_HIGH: name_off = {1'b1, ppu_addr[9:0]};
			sbsm_pkg::MIRROR_VERTICAL: name_off = {ppu_addr[10], ppu_addr[9:0]};
			default:                   name_off = {ppu_addr[11], ppu_addr[9:0]};
		endcase

		pal = ppu_addr[4:0];
		if (pal[1:0] == 2'd0) begin
			pal[4] = 1'b0;
		end
	end

	always_comb begin
		target       = sbsm_pkg::TGT_NONE;
		phys_address = '0;
		if (op == sbsm_pkg::OP_CPU_READ || op == sbsm_pkg::OP_CPU_WRITE) begin
			if (address[15]) begin
				if (op == sbsm_pkg::OP_CPU_READ) begin
					target       = sbsm_pkg::TGT_PRG_ROM;
					phys_address = {prg_bank, address[13:0]};
				end
			end else if (address[14:13] == 2'b11) begin
				target       = sbsm_pkg::TGT_PRG_RAM;
				phys_address = {5'd0, address[12:0]};
			end
		end else if (!ppu_addr[13]) begin
			target       = sbsm_pkg::TGT_CHR;
			phys_address = {1'b0, chr_unit, ppu_addr[11:0]};
		end else if (ppu_addr[13:8] == 6'h3F) begin
			target       = sbsm_pkg::TGT_PALETTE;
			phys_address = {13'd0, pal};
		end else begin
			target       = sbsm_pkg::TGT_NAME;
			phys_address = {7'd0, name_off};
		end
	end

endmodule

### rtl/core/serial_bank_switch_mapper_top.sv
`timescale 1ns / 1ps
`include "serial_bank_switch_mapper_top_macros.svh"

// Cartridge bank controller. Each transfer on the s_ channel is one bus access
// (op, address, write data); each transfer on the m_ channel is its translation
// into a target memory and a byte offset within that memory, one per access, in order.
// CPU writes at 0x8000 and above feed the five bit serial loader instead of a memory.
// The bank counts are set through cfg_we, cfg_index and cfg_data; write them only
// while no access is in flight.
// Each access is held in the input register, where the translation and any loader update
// are done, and its result is then registered in the result register, which offers it.
// Throughput is one access per cycle while the receiver keeps m_tready high; the loader
// state is updated as an access leaves the input register, so the next access sees it.
// When the receiver holds m_tready low, the result register holds its transfer, the
// input register fills, and s_tready falls; nothing is dropped.
// Reset empties both registers and clears the loader, and returns the bank counts to two
// program banks and one pattern bank, with the fixed high program bank mode.
module serial_bank_switch_mapper_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // op[1:0], address[17:2], write_data[25:18], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // target[2:0], phys_address[20:3], zero
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);

	logic        s1_valid_q;
	logic [1:0]  op_s1;
	logic [15:0] address_s1;
	logic [7:0]  write_data_s1;
	logic        out_valid_q;
	logic [2:0]  target_s2;
	logic [17:0] phys_s2;

	logic        s_fire;
	logic        s1_advance;
	logic        loader_wr;
	logic [2:0]  target;
	logic [17:0] phys_address;

	sbsm_pkg::bank_state_t state;

	assign s1_advance = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready   = !s1_valid_q || s1_advance;
	assign s_fire     = s_tvalid && s_tready;
	assign loader_wr  = s1_advance && op_s1 == sbsm_pkg::OP_CPU_WRITE && address_s1[15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_s1         <= s_tdata[1:0];
			address_s1    <= s_tdata[17:2];
			write_data_s1 <= s_tdata[25:18];
		end
	end

	sbsm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr_en     (loader_wr),
		.wr_sel    (address_s1[14:13]),
		.wr_data   (write_data_s1),
		.state     (state)
	);

	sbsm_xlate u_xlate (
		.op           (op_s1),
		.address      (address_s1),
		.state        (state),
		.target       (target),
		.phys_address (phys_address)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			target_s2 <= target;
			phys_s2   <= phys_address;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, phys_s2, target_s2};

	`SBSM_ASSERT_NEXT(a_loader_write_result, loader_wr,
		m_tvalid && m_tdata[2:0] == sbsm_pkg::TGT_NONE && m_tdata[20:3] == 18'd0,
		"register write did not give an empty result")
	`SBSM_ASSERT_ALWAYS(a_full_blocks_input, !(s1_valid_q && out_valid_q && !m_tready) || !s_tready,
		"input taken while both registers are full and the output is stalled")
	`SBSM_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata),
		"stalled result changed before its transfer")

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import sbsm_pkg::*;

	localparam int IDLE_LIMIT = 1000;

	typedef struct packed {
		logic [2:0]  target;
		logic [17:0] phys;
	} xlat_t;

	class bank_translator;
		logic [4:0] prg_count;
		logic [4:0] chr_count;
		logic [4:0] shift_value;
		logic [2:0] shift_count;
		logic       chr_4k;
		logic [1:0] prg_mode;
		logic [1:0] mirror;
		logic [4:0] chr_low;
		logic [4:0] chr_high;
		logic [3:0] prg_sel;
		logic       ram_enable;
		xlat_t      due[$];
		int         errors;

		function new();
			prg_count = PRG_COUNT_RESET;
			chr_count = CHR_COUNT_RESET;
			shift_value = '0;
			shift_count = '0;
			chr_4k = 1'b0;
			prg_mode = PRG_MODE_FIX_HIGH;
			mirror = MIRROR_ONE_LOW;
			chr_low = '0;
			chr_high = '0;
			prg_sel = '0;
			ram_enable = 1'b0;
			errors = 0;
		endfunction

		function void set_count(logic idx, logic [4:0] value);
			if (idx == CFG_PRG_COUNT) begin
				prg_count = value;
			end else begin
				chr_count = value;
			end
		endfunction

		function logic [3:0] prg_mask();
			int n;
			n = prg_count;
			if (n < 1) n = 1;
			if (n > MAX_PRG_BANKS) n = MAX_PRG_BANKS;
			return 4'(n - 1);
		endfunction

		function logic [4:0] chr_mask();
			int n;
			n = chr_count;
			if (n < 1) n = 1;
			if (n > MAX_CHR_BANKS) n = MAX_CHR_BANKS;
			return 5'(2 * n - 1);
		endfunction

		// A write with bit 7 set abandons the load and forces the fixed high bank mode; otherwise bit 0 is shifted in,
		// and the fifth bit commits the value to the register picked by address bits 14:13.
		function void shift_in(logic [15:0] addr, logic [7:0] data);
			if (data[7]) begin
				shift_value = '0;
				shift_count = '0;
				prg_mode = PRG_MODE_FIX_HIGH;
				return;
			end
			shift_value = shift_value | (5'(data[0]) << shift_count);
			shift_count = shift_count + 3'd1;
			if (shift_count <= SHIFT_LAST) return;
			case (addr[14:13])
				SEL_CONTROL: begin
					chr_4k = shift_value[4];
					prg_mode = shift_value[3:2];
					mirror = shift_value[1:0];
				end
				SEL_CHR_LOW: chr_low = shift_value & chr_mask();
				SEL_CHR_HIGH: chr_high = shift_value & chr_mask();
				default: begin
					ram_enable = shift_value[4];
					prg_sel = shift_value[3:0] & prg_mask();
				end
			endcase
			shift_value = '0;
			shift_count = '0;
		endfunction

		function logic [17:0] prg_offset(logic [15:0] addr);
			logic [3:0] m;
			logic [3:0] lo;
			logic [3:0] hi;
			logic [3:0] bank;
			m = prg_mask();
			case (prg_mode)
				PRG_MODE_FIX_HIGH: begin
					lo = prg_sel;
					hi = m;
				end
				PRG_MODE_FIX_LOW: begin
					lo = '0;
					hi = prg_sel;
				end
				default: begin
					lo = prg_sel & 4'he & m;
					hi = (lo | 4'h1) & m;
				end
			endcase
			bank = addr[14] ? hi : lo;
			return {bank, addr[13:0]};
		endfunction

		function logic [17:0] chr_offset(logic [13:0] a);
			logic [4:0] unit;
			if (chr_4k) begin
				unit = a[12] ? chr_high : chr_low;
			end else begin
				unit = {chr_low[4:1], a[12]};
			end
			return {1'b0, unit, a[11:0]};
		endfunction

		function logic [17:0] name_offset(logic [13:0] a);
			logic [10:0] r;
			case (mirror)
				MIRROR_ONE_LOW: r = {1'b0, a[9:0]};
				MIRROR_ONE_HIGH: r = {1'b1, a[9:0]};
				MIRROR_VERTICAL: r = {a[10], a[9:0]};
				default: r = {a[11], a[9:0]};
			endcase
			return {7'b0, r};
		endfunction

		function void note_access(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
			xlat_t      x;
			logic [13:0] a;
			logic [4:0] p;
			x.target = TGT_NONE;
			x.phys = '0;
			a = addr[13:0];
			if (op == OP_CPU_READ || op == OP_CPU_WRITE) begin
				if (addr[15]) begin
					if (op == OP_CPU_READ) begin
						x.target = TGT_PRG_ROM;
						x.phys = prg_offset(addr);
					end else begin
						shift_in(addr, data);
					end
				end else if (addr >= 16'h6000) begin
					x.target = TGT_PRG_RAM;
					x.phys = {5'b0, addr[12:0]};
				end
			end else if (!a[13]) begin
				x.target = TGT_CHR;
				x.phys = chr_offset(a);
			end else if (a[13:8] == 6'h3f) begin
				p = a[4:0];
				if (p[1:0] == 2'b00) p[4] = 1'b0;
				x.target = TGT_PALETTE;
				x.phys = {13'b0, p};
			end else begin
				x.target = TGT_NAME;
				x.phys = name_offset(a);
			end
			due.push_back(x);
		endfunction

		function void check_translation(logic [2:0] target, logic [17:0] phys);
			xlat_t want;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: target %0d phys 0x%05h",
					$time, target, phys);
				return;
			end
			want = due.pop_front();
			if (target !== want.target) begin
				errors++;
				$display("%0t: target expected %0d, got %0d", $time, want.target, target);
			end
			if (phys !== want.phys) begin
				errors++;
				$display("%0t: phys_address expected 0x%05h, got 0x%05h",
					$time, want.phys, phys);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_PRG_COUNT;
	logic [4:0]  cfg_data = '0;

	bank_translator xlat = new();
	bit steady = 1'b0;
	bit hold_request = 1'b0;
	int sent_items = 0;
	int idle_cycles = 0;

	serial_bank_switch_mapper_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) xlat.set_count(cfg_index, cfg_data);
			if (s_tvalid && s_tready) xlat.note_access(s_tdata[1:0], s_tdata[17:2], s_tdata[25:18]);
			if (m_tvalid && m_tready) xlat.check_translation(m_tdata[2:0], m_tdata[20:3]);
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("FAIL serial_bank_switch_mapper_top");
		$finish;
	end

	function automatic int pick_gap();
		int roll;
		if (steady) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// The receiver accepts with random gaps, and holds off for a long stretch whenever the stimulus asks for it.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = 80;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	task automatic send_access(input logic [1:0] op, input logic [15:0] addr,
			input logic [7:0] data);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, data, addr, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_items++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (xlat.due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(input logic idx, input logic [4:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_access();
		logic [1:0]  op;
		logic [15:0] addr;
		op = 2'($urandom_range(0, 3));
		addr = 16'($urandom);
		case (op)
			OP_CPU_READ: begin
				case ($urandom_range(0, 3))
					0: addr[15] = 1'b1;
					1: addr = 16'h6000 + 16'($urandom_range(0, 16'h1fff));
					2: ;
					default: addr = 16'($urandom_range(0, 16'h5fff));
				endcase
			end
			OP_CPU_WRITE: begin
				if ($urandom_range(0, 7) != 0) addr[15] = 1'b0;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: addr[13:8] = 6'h3f;
					1: addr[13] = 1'b0;
					default: ;
				endcase
			end
		endcase
		send_access(op, addr, 8'($urandom));
	endtask

	task automatic load_register(input logic [1:0] sel, input logic [4:0] value);
		logic [15:0] addr;
		if ($urandom_range(0, 2) == 0)
			send_access(OP_CPU_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
		for (int i = 0; i < 5; i++) begin
			if ($urandom_range(0, 9) == 0) random_access();
			if ($urandom_range(0, 24) == 0) begin
				send_access(OP_CPU_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
				return;
			end
			addr = {1'b1, (i == 4) ? sel : 2'($urandom), 13'($urandom)};
			send_access(OP_CPU_WRITE, addr, {1'b0, 6'($urandom), value[i]});
		end
	endtask

	task automatic run_random(input int quota);
		int start;
		start = sent_items;
		while (sent_items - start < quota) begin
			if ($urandom_range(0, 29) == 0) steady = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 9) < 4) begin
				load_register(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
			end else begin
				random_access();
			end
		end
	endtask

	initial begin
		int prg_list[8];
		int chr_list[8];
		prg_list = '{1, 16, 4, 0, 31, 8, 3, 16};
		chr_list = '{1, 16, 8, 0, 31, 2, 5, 1};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_access(OP_CPU_READ, 16'h0000, 8'hff);
		send_access(OP_CPU_READ, 16'h5fff, 8'h00);
		send_access(OP_CPU_READ, 16'h6000, 8'h00);
		send_access(OP_CPU_WRITE, 16'h7fff, 8'h55);
		send_access(OP_CPU_READ, 16'h8000, 8'h00);
		send_access(OP_CPU_READ, 16'hffff, 8'h00);
		send_access(OP_PPU_READ, 16'h0000, 8'h00);
		send_access(OP_PPU_WRITE, 16'h1fff, 8'haa);
		send_access(OP_PPU_READ, 16'h2000, 8'h00);
		send_access(OP_PPU_READ, 16'h2c00, 8'h00);
		send_access(OP_PPU_WRITE, 16'h3eff, 8'h00);
		send_access(OP_PPU_READ, 16'h3000, 8'h00);
		send_access(OP_PPU_READ, 16'h3f00, 8'h00);
		send_access(OP_PPU_READ, 16'h3f10, 8'h00);
		send_access(OP_PPU_READ, 16'h3f1f, 8'h00);
		send_access(OP_PPU_READ, 16'hffff, 8'h00);
		send_access(OP_CPU_WRITE, 16'h8000, 8'h80);
		// Control load of 11011b: 4K pattern units, fixed low program bank, horizontal.
		send_access(OP_CPU_WRITE, 16'h8000, 8'h7f);
		send_access(OP_CPU_WRITE, 16'h8000, 8'h7f);
		send_access(OP_CPU_WRITE, 16'h8000, 8'h7e);
		send_access(OP_CPU_WRITE, 16'h8000, 8'h7f);
		send_access(OP_CPU_WRITE, 16'h8000, 8'h7f);
		send_access(OP_CPU_READ, 16'hc000, 8'h00);
		send_access(OP_PPU_READ, 16'h1000, 8'h00);
		send_access(OP_CPU_WRITE, 16'he000, 8'hff);

		run_random(150);

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			write_count(CFG_PRG_COUNT, 5'(prg_list[ph]));
			write_count(CFG_CHR_COUNT, 5'(chr_list[ph]));
			if (ph == 1) begin
				steady = 1'b1;
				hold_request = 1'b1;
				repeat (20) random_access();
			end
			run_random(158);
		end

		drain();
		repeat (8) @(posedge clk);
		if (xlat.errors == 0 && xlat.due.size() == 0) begin
			$display("PASS serial_bank_switch_mapper_top");
		end else begin
			$display("FAIL serial_bank_switch_mapper_top");
		end
		$finish;
	end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/sbsm_pkg.sv
rtl/core/sbsm_regs.sv
rtl/core/sbsm_xlate.sv
rtl/core/serial_bank_switch_mapper_top.sv
bench/tb.sv
